FILE: hdl/plom_pkg.sv
// shared types and constants for the price level order matcher
// no dependencies
package plom_pkg;

    localparam logic DIR_BUY  = 1'b0;
    localparam logic DIR_SELL = 1'b1;

    localparam logic KIND_FILL   = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    // one order as it travels from the front part to the matching engine
    typedef struct packed {
        logic [1:0]  symbol;
        logic [7:0]  price;
        logic        side;
        logic [15:0] order_size;
        logic [7:0]  trader_id;
        logic        bad;
    } order_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  trader;
        logic        side;
        logic [15:0] size;
        logic [1:0]  symbol;
        logic [7:0]  price;
        logic        last;
    } result_t;

endpackage

FILE: hdl/plom_front.sv
// order intake: range check and a small queue toward the matching engine
// depends on plom_pkg
module plom_front #(
    parameter int SYMBOLS      = 3,
    parameter int PRICE_LEVELS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           symbol,
    input  logic [7:0]           price,
    input  logic                 side,
    input  logic [15:0]          order_size,
    input  logic [7:0]           trader_id,
    output logic                 q_valid,
    input  logic                 q_ready,
    output plom_pkg::order_t     q_order
);

    plom_pkg::order_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    plom_pkg::order_t cur;
    logic push, pop;

    always_comb
    begin
        cur.symbol     = symbol;
        cur.price      = price;
        cur.side       = side;
        cur.order_size = order_size;
        cur.trader_id  = trader_id;
        cur.bad        = (32'(symbol) >= 32'(SYMBOLS)) || (32'(price) >= 32'(PRICE_LEVELS));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_order  = slot_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= cur;
    end

endmodule

FILE: hdl/plom_engine.sv
// matching engine: level tables, offer memory and the fill sequencer
// depends on plom_pkg
module plom_engine #(
    parameter int SYMBOLS      = 3,
    parameter int PRICE_LEVELS = 256,
    parameter int QUEUE_DEPTH  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  plom_pkg::order_t     q_order,
    output logic                 r_valid,
    input  logic                 r_ready,
    output plom_pkg::result_t    r_item
);

    localparam int LEVELS = SYMBOLS * PRICE_LEVELS;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = LW + QW;
    localparam int TW = 16 + CW;
    localparam int LVW = CW + QW + 1 + TW;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_LOOK  = 4'd2;
    localparam logic [3:0] ST_DEC   = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_WAIT  = 4'd5;
    localparam logic [3:0] ST_WALK  = 4'd6;
    localparam logic [3:0] ST_TAIL  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_EMITQ = 4'd9;

    localparam logic [1:0] M_EQ  = 2'd0;
    localparam logic [1:0] M_BIG = 2'd1;
    localparam logic [1:0] M_SML = 2'd2;
    localparam logic [1:0] M_ADD = 2'd3;

    // level memory, cleared by a sweep after reset
    logic [LVW-1:0] lvl_mem [LEVELS];
    logic [LVW-1:0] lvl_rd_reg;
    logic [23:0]    off_mem [LEVELS * QUEUE_DEPTH];
    logic [23:0]    off_rd_reg;

    logic [3:0]   st_reg, st_next;
    logic [LW-1:0] clr_reg, clr_next;
    plom_pkg::order_t ord_reg;
    logic [LW-1:0] lv_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] head_reg, head_next;
    logic          rs_reg, rs_next;
    logic [TW-1:0] tot_reg, tot_next;
    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] i_reg, i_next;
    logic [16:0]   acc_reg, acc_next;
    logic [CW-1:0] cons_reg, cons_next;
    logic          ob_full;

    logic          lvl_we;
    logic [LVW-1:0] lvl_wd;
    logic          off_we;
    logic [SW-1:0] off_wa;
    logic [23:0]   off_wd;
    logic [SW-1:0] off_ra;
    logic          emit;
    plom_pkg::result_t em;
    plom_pkg::result_t ob_reg;
    logic          ob_valid_reg;

    logic [LW-1:0] lv_calc;
    logic [QW-1:0] slot_i;
    logic [16:0]   sum;
    logic [15:0]   osz;

    function automatic logic [QW-1:0] wrapq(input logic [CW:0] v);
        logic [CW:0] d;
        d = (CW+1)'(QUEUE_DEPTH);
        return (v >= d) ? QW'(v - d) : QW'(v);
    endfunction

    assign lv_calc = LW'(32'(q_order.symbol) * PRICE_LEVELS + 32'(q_order.price));
    assign slot_i  = wrapq((CW+1)'(head_reg) + (CW+1)'(i_reg));
    assign osz     = off_rd_reg[15:0];
    assign sum     = acc_reg + 17'(osz);
    assign ob_full = ob_valid_reg && !r_ready;
    assign q_ready = (st_reg == ST_IDLE);
    assign r_valid = ob_valid_reg;
    assign r_item  = ob_reg;
    assign off_ra  = SW'(32'(lv_reg) * QUEUE_DEPTH + 32'(slot_i));

    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        cnt_next  = cnt_reg;
        head_next = head_reg;
        rs_next   = rs_reg;
        tot_next  = tot_reg;
        mode_next = mode_reg;
        i_next    = i_reg;
        acc_next  = acc_reg;
        cons_next = cons_reg;
        lvl_we    = 1'b0;
        lvl_wd    = '0;
        off_we    = 1'b0;
        off_wa    = '0;
        off_wd    = '0;
        emit      = 1'b0;
        em.kind   = plom_pkg::KIND_FILL;
        em.trader = ord_reg.trader_id;
        em.side   = ord_reg.side;
        em.size   = ord_reg.order_size;
        em.symbol = ord_reg.symbol;
        em.price  = ord_reg.price;
        em.last   = 1'b0;
        case (st_reg)
            ST_CLEAR:
            begin
                lvl_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == LEVELS - 1)
                    st_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                    st_next = q_order.bad ? ST_EMITQ : ST_LOOK;
            end
            ST_EMITQ:
            begin
                // reject of an out-of-range order or of one that finds its level queue full
                if (!ob_full)
                begin
                    emit = 1'b1;
                    em.kind = plom_pkg::KIND_REJECT;
                    em.last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                st_next = ST_DEC;
            end
            ST_DEC:
            begin
                {cnt_next, head_next, rs_next, tot_next} = lvl_rd_reg;
                st_next = ST_RD;
                if (lvl_rd_reg[LVW-1 -: CW] == '0 ||
                    ord_reg.side == lvl_rd_reg[TW])
                begin
                    if (32'(lvl_rd_reg[LVW-1 -: CW]) >= QUEUE_DEPTH)
                        st_next = ST_EMITQ;
                    else
                        st_next = ST_FIN;
                    mode_next = M_ADD;
                end
                else if (TW'(ord_reg.order_size) == lvl_rd_reg[TW-1:0])
                    mode_next = M_EQ;
                else if (TW'(ord_reg.order_size) > lvl_rd_reg[TW-1:0])
                    mode_next = M_BIG;
                else
                    mode_next = M_SML;
                i_next = '0;
                acc_next = '0;
                cons_next = lvl_rd_reg[LVW-1 -: CW];
            end
            ST_RD:
            begin
                // buy order on equal totals and smaller order report first
                if ((mode_reg == M_EQ && ord_reg.side == plom_pkg::DIR_BUY) ||
                    mode_reg == M_SML)
                begin
                    if (!ob_full)
                    begin
                        emit = 1'b1;
                        st_next = ST_WAIT;
                    end
                end
                else
                    st_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                st_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (!ob_full)
                begin
                    emit = 1'b1;
                    em.trader = off_rd_reg[23:16];
                    em.side = rs_reg;
                    em.size = osz;
                    i_next = i_reg + 1'b1;
                    st_next = ST_WAIT;
                    if (mode_reg == M_SML)
                    begin
                        acc_next = sum;
                        if (sum > 17'(ord_reg.order_size))
                        begin
                            em.size = 16'(17'(ord_reg.order_size) - acc_reg);
                            off_we = 1'b1;
                            off_wa = off_ra;
                            off_wd = {off_rd_reg[23:16],
                                      16'(17'(osz) - 17'(ord_reg.order_size) + acc_reg)};
                            cons_next = i_reg;
                            em.last = 1'b1;
                            st_next = ST_FIN;
                        end
                        else if (sum == 17'(ord_reg.order_size))
                        begin
                            cons_next = i_reg + 1'b1;
                            em.last = 1'b1;
                            st_next = ST_FIN;
                        end
                        else if (i_reg + 1'b1 == cnt_reg)
                        begin
                            em.last = 1'b1;
                            st_next = ST_FIN;
                        end
                    end
                    else if (i_reg + 1'b1 == cnt_reg)
                    begin
                        if (mode_reg == M_EQ && ord_reg.side == plom_pkg::DIR_BUY)
                        begin
                            em.last = 1'b1;
                            st_next = ST_FIN;
                        end
                        else
                            st_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (!ob_full)
                begin
                    emit = 1'b1;
                    em.last = 1'b1;
                    if (mode_reg == M_BIG)
                        em.size = 16'(tot_reg);
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                lvl_we = 1'b1;
                st_next = ST_IDLE;
                case (mode_reg)
                    M_EQ:
                        lvl_wd = {CW'(0), QW'(0), rs_reg, TW'(0)};
                    M_BIG:
                    begin
                        lvl_wd = {CW'(1), QW'(0), ord_reg.side,
                                  TW'(ord_reg.order_size) - tot_reg};
                        off_we = 1'b1;
                        off_wa = SW'(32'(lv_reg) * QUEUE_DEPTH);
                        off_wd = {ord_reg.trader_id, 16'(TW'(ord_reg.order_size) - tot_reg)};
                    end
                    M_SML:
                        lvl_wd = {cnt_reg - cons_reg,
                                  wrapq((CW+1)'(head_reg) + (CW+1)'(cons_reg)),
                                  rs_reg, tot_reg - TW'(ord_reg.order_size)};
                    default:
                    begin
                        // append a resting offer
                        off_we = 1'b1;
                        if (cnt_reg == '0)
                        begin
                            off_wa = SW'(32'(lv_reg) * QUEUE_DEPTH);
                            lvl_wd = {CW'(1), QW'(0), ord_reg.side,
                                      TW'(ord_reg.order_size)};
                        end
                        else
                        begin
                            off_wa = SW'(32'(lv_reg) * QUEUE_DEPTH + 32'(wrapq(
                                     (CW+1)'(head_reg) + (CW+1)'(cnt_reg))));
                            lvl_wd = {cnt_reg + 1'b1, head_reg, rs_reg,
                                      tot_reg + TW'(ord_reg.order_size)};
                        end
                        off_wd = {ord_reg.trader_id, ord_reg.order_size};
                    end
                endcase
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_CLEAR;
            clr_reg      <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (emit)
                ob_valid_reg <= 1'b1;
            else if (r_ready)
                ob_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            ord_reg <= q_order;
            lv_reg  <= lv_calc;
        end
        cnt_reg  <= cnt_next;
        head_reg <= head_next;
        rs_reg   <= rs_next;
        tot_reg  <= tot_next;
        mode_reg <= mode_next;
        i_reg    <= i_next;
        acc_reg  <= acc_next;
        cons_reg <= cons_next;
        if (emit)
            ob_reg <= em;
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
            lvl_mem[(st_reg == ST_CLEAR) ? clr_reg : lv_reg] <= lvl_wd;
        lvl_rd_reg <= lvl_mem[lv_reg];
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
            off_mem[off_wa] <= off_wd;
        off_rd_reg <= off_mem[off_ra];
    end

endmodule

FILE: hdl/price_level_order_matcher_core.sv
// an accepted order yields either a reject or its fills, passed out one result at a time
// an order walking resting offers holds the engine through the offer
// memory read loop of the matching engine: one offer read and one result per offer
// throughput: one order at a time in the engine, a two-entry queue in front
// reset: asynchronous active low; the level memory is then swept over all
// SYMBOLS*PRICE_LEVELS levels (768 by default) before orders are taken
module price_level_order_matcher_core #(
    parameter int SYMBOLS      = 3,
    parameter int PRICE_LEVELS = 256,
    parameter int QUEUE_DEPTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  symbol,
    input  logic [7:0]  price,
    input  logic        side,
    input  logic [15:0] order_size,
    input  logic [7:0]  trader_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  fill_trader,
    output logic        fill_side,
    output logic [15:0] fill_size,
    output logic [1:0]  fill_symbol,
    output logic [7:0]  fill_price,
    output logic        last
);

    logic q_valid, q_ready;
    plom_pkg::order_t  q_order;
    plom_pkg::result_t r_item;

    plom_front #(.SYMBOLS(SYMBOLS), .PRICE_LEVELS(PRICE_LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .symbol(symbol), .price(price), .side(side),
        .order_size(order_size), .trader_id(trader_id),
        .q_valid(q_valid), .q_ready(q_ready), .q_order(q_order)
    );

    plom_engine #(.SYMBOLS(SYMBOLS), .PRICE_LEVELS(PRICE_LEVELS),
                  .QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_order(q_order),
        .r_valid(out_valid), .r_ready(out_ready), .r_item(r_item)
    );

    assign kind        = r_item.kind;
    assign fill_trader = r_item.trader;
    assign fill_side   = r_item.side;
    assign fill_size   = r_item.size;
    assign fill_symbol = r_item.symbol;
    assign fill_price  = r_item.price;
    assign last        = r_item.last;

endmodule

FILE: hdl/plom_checker.sv
// port-level checks for the matcher core, bound to the top level
// depends on nothing but the top level ports
module plom_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [15:0] fill_size,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fill_size) && $stable(last))
        else $error("result changed while stalled");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> last)
        else $error("reject not final");

    a_no_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({kind, last}))
        else $error("unknown result control");

endmodule

bind price_level_order_matcher_core plom_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .fill_size(fill_size), .last(last)
);
